@@ rtl/astm_pkg.sv @@
// Shared types, constants and the arctangent table of the angular spectrum multiplier.
// No dependencies; every other file of the block except astm_ifs imports this package.
`default_nettype none
package astm_pkg;

  localparam int SQ_STEPS     = 32;
  localparam int RAD_W        = 62;
  localparam int ROOT_W       = 63;
  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 34;

  localparam logic signed [CW-1:0] CORDIC_INV_GAIN = 34'sd652032874;

  localparam logic [1:0] REG_INV_WAVELENGTH_SQ = 2'd0;
  localparam logic [1:0] REG_PROP_DISTANCE     = 2'd1;
  localparam logic [1:0] REG_HALF_BAND_U       = 2'd2;
  localparam logic [1:0] REG_HALF_BAND_V       = 2'd3;

  typedef enum logic [1:0] {
    REGION_OUTSIDE     = 2'd0,
    REGION_EVANESCENT  = 2'd1,
    REGION_PROPAGATING = 2'd2
  } region_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] re;
    logic signed [15:0] im;
    region_t            region;
  } side_t;

  // Arctangent of 2^-i in turns, 2^32 to one turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/astm_ifs.sv @@
// Valid/ready stream interfaces for the sample input and the result output.
// Uses no package.
`default_nettype none
interface astm_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] freq_u;
  logic signed [23:0] freq_v;
  logic signed [15:0] sample_re;
  logic signed [15:0] sample_im;
  modport source (output valid, freq_u, freq_v, sample_re, sample_im, input ready);
  modport sink   (input valid, freq_u, freq_v, sample_re, sample_im, output ready);
endinterface

interface astm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_re;
  logic signed [15:0] result_im;
  logic [1:0]         region;
  modport source (output valid, result_re, result_im, region, input ready);
  modport sink   (input valid, result_re, result_im, region, output ready);
endinterface
`default_nettype wire

@@ rtl/angular_spectrum_transfer_multiply_top.sv @@
// Band-limited angular spectrum transfer multiply: top level with register port.
// Depends on astm_pkg, astm_ifs, astm_sqrt_cell and astm_cordic_cell.
// Throughput is one transaction per cycle while the output is not stalled, set by the fully
// pipelined square root and rotation cell rows.
// The whole pipeline advances together and halts only while a result waits unaccepted.
// Synchronous active-low reset clears all valid flags and loads the register reset values.
`default_nettype none
module angular_spectrum_transfer_multiply_top
  import astm_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  astm_in_if.sink     in_ch,
  astm_out_if.source  out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  // Configuration registers. Writes must arrive only while the pipeline is empty, which the
  // block itself does not enforce; every stage reads them directly.
  logic [44:0] inv_wl_sq_r;
  logic [31:0] distance_r;
  logic [22:0] half_u_r, half_v_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_wl_sq_r <= 45'd4398046511104;
      distance_r  <= 32'd0;
      half_u_r    <= 23'h7FFFFF;
      half_v_r    <= 23'h7FFFFF;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_INV_WAVELENGTH_SQ: inv_wl_sq_r <= pwdata[44:0];
        REG_PROP_DISTANCE:     distance_r  <= pwdata[31:0];
        REG_HALF_BAND_U:       half_u_r    <= pwdata[22:0];
        REG_HALF_BAND_V:       half_v_r    <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_INV_WAVELENGTH_SQ: prdata = {19'd0, inv_wl_sq_r};
      REG_PROP_DISTANCE:     prdata = {32'd0, distance_r};
      REG_HALF_BAND_U:       prdata = {41'd0, half_u_r};
      REG_HALF_BAND_V:       prdata = {41'd0, half_v_r};
      default:               prdata = 64'd0;
    endcase
  end

  // A single advance signal moves every stage. The pipeline only halts when the
  // output register holds a result that the sink has not yet taken.
  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: band test and the two frequency squares.
  side_t              s1_side_r, s1_side_nxt;
  logic [46:0]        fx2_r, fy2_r;
  logic signed [47:0] fx2_full, fy2_full;
  logic [24:0]        ax, ay;

  always_comb begin
    ax = in_ch.freq_u[23] ? 25'(-$signed({in_ch.freq_u[23], in_ch.freq_u}))
                          : {1'b0, in_ch.freq_u};
    ay = in_ch.freq_v[23] ? 25'(-$signed({in_ch.freq_v[23], in_ch.freq_v}))
                          : {1'b0, in_ch.freq_v};
    fx2_full = in_ch.freq_u * in_ch.freq_u;
    fy2_full = in_ch.freq_v * in_ch.freq_v;
    s1_side_nxt.valid = in_ch.valid;
    s1_side_nxt.re    = in_ch.sample_re;
    s1_side_nxt.im    = in_ch.sample_im;
    // Inclusive limits: a frequency sitting exactly on the band edge stays inside.
    s1_side_nxt.region = (ax > {2'b00, half_u_r} || ay > {2'b00, half_v_r})
                         ? REGION_OUTSIDE : REGION_PROPAGATING;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.valid <= 1'b0;
    end else if (en) begin
      s1_side_r <= s1_side_nxt;
      fx2_r     <= fx2_full[46:0];
      fy2_r     <= fy2_full[46:0];
    end
  end

  // Stage 2: w = 1/lambda^2 - fx^2 - fy^2 and the final region. Zero w counts as
  // evanescent. Non-propagating samples feed a zero radicand to the root chain.
  side_t              s2_side_r, s2_side_nxt;
  logic [RAD_W-1:0]   s2_rad_r, s2_rad_nxt;
  logic signed [48:0] w;
  logic               w_pos;

  always_comb begin
    w = $signed({4'b0000, inv_wl_sq_r}) - $signed({2'b00, fx2_r}) - $signed({2'b00, fy2_r});
    w_pos = !w[48] && (w != 49'sd0);
    s2_side_nxt = s1_side_r;
    s2_rad_nxt  = '0;
    if (s1_side_r.region == REGION_PROPAGATING) begin
      if (w_pos) begin
        s2_rad_nxt = {w[45:0], 16'd0};
      end else begin
        s2_side_nxt.region = REGION_EVANESCENT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.valid <= 1'b0;
    end else if (en) begin
      s2_side_r <= s2_side_nxt;
      s2_rad_r  <= s2_rad_nxt;
    end
  end

  // Square root row: one result bit per cell, the radicand shrinking as it goes.
  side_t             sq_side [SQ_STEPS+1];
  logic [RAD_W-1:0]  sq_v    [SQ_STEPS+1];
  logic [ROOT_W-1:0] sq_res  [SQ_STEPS+1];

  assign sq_side[0] = s2_side_r;
  assign sq_v[0]    = s2_rad_r;
  assign sq_res[0]  = '0;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    astm_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .step     (5'(k)),
      .side_in  (sq_side[k]),
      .v_in     (sq_v[k]),
      .res_in   (sq_res[k]),
      .side_out (sq_side[k+1]),
      .v_out    (sq_v[k+1]),
      .res_out  (sq_res[k+1])
    );
  end

  // Phase in turns: the root times the distance; bits 35..4 form the angle.
  side_t       ph_side_r;
  logic [31:0] angle_r;
  logic [62:0] turns;

  assign turns = sq_res[SQ_STEPS][30:0] * distance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_side_r.valid <= 1'b0;
    end else if (en) begin
      ph_side_r <= sq_side[SQ_STEPS];
      angle_r   <= turns[35:4];
    end
  end

  // Angles in the left half plane are folded by half a turn, with x starting negative.
  side_t                cr_side [CORDIC_STEPS+1];
  logic signed [CW-1:0] cr_x    [CORDIC_STEPS+1];
  logic signed [CW-1:0] cr_y    [CORDIC_STEPS+1];
  logic signed [CW-1:0] cr_z    [CORDIC_STEPS+1];
  logic                 fold;
  logic [31:0]          r_angle;

  assign fold       = angle_r[31] ^ angle_r[30];
  assign r_angle    = fold ? {~angle_r[31], angle_r[30:0]} : angle_r;
  assign cr_side[0] = ph_side_r;
  assign cr_x[0]    = fold ? -CORDIC_INV_GAIN : CORDIC_INV_GAIN;
  assign cr_y[0]    = '0;
  assign cr_z[0]    = CW'($signed(r_angle));

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    astm_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .step     (5'(k)),
      .side_in  (cr_side[k]),
      .x_in     (cr_x[k]),
      .y_in     (cr_y[k]),
      .z_in     (cr_z[k]),
      .side_out (cr_side[k+1]),
      .x_out    (cr_x[k+1]),
      .y_out    (cr_y[k+1]),
      .z_out    (cr_z[k+1])
    );
  end

  // Complex multiply: the four partial products are registered on their own.
  side_t              pm_side_r;
  logic signed [49:0] p_rc_r, p_is_r, p_rs_r, p_ic_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pm_side_r.valid <= 1'b0;
    end else if (en) begin
      pm_side_r <= cr_side[CORDIC_STEPS];
      p_rc_r    <= cr_side[CORDIC_STEPS].re * cr_x[CORDIC_STEPS];
      p_is_r    <= cr_side[CORDIC_STEPS].im * cr_y[CORDIC_STEPS];
      p_rs_r    <= cr_side[CORDIC_STEPS].re * cr_y[CORDIC_STEPS];
      p_ic_r    <= cr_side[CORDIC_STEPS].im * cr_x[CORDIC_STEPS];
    end
  end

  // Output register: round half up from 45 to 15 fraction bits, then saturate.
  logic signed [50:0] re_sum, im_sum;
  logic signed [20:0] re_sh, im_sh;
  logic signed [15:0] re_sat, im_sat, re_sel, im_sel;
  logic signed [15:0] out_re_r, out_im_r;
  region_t            out_region_r;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -21'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    re_sum = 51'(p_rc_r) - 51'(p_is_r) + 51'sd536870912;
    im_sum = 51'(p_rs_r) + 51'(p_ic_r) + 51'sd536870912;
    re_sh  = re_sum[50:30];
    im_sh  = im_sum[50:30];
    re_sat = sat16(re_sh);
    im_sat = sat16(im_sh);
    case (pm_side_r.region)
      REGION_OUTSIDE: begin
        re_sel = '0;
        im_sel = '0;
      end
      REGION_EVANESCENT: begin
        re_sel = pm_side_r.re;
        im_sel = pm_side_r.im;
      end
      default: begin
        re_sel = re_sat;
        im_sel = im_sat;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r  <= pm_side_r.valid;
      out_re_r     <= re_sel;
      out_im_r     <= im_sel;
      out_region_r <= pm_side_r.region;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.result_re = out_re_r;
  assign out_ch.result_im = out_im_r;
  assign out_ch.region    = out_region_r;

endmodule
`default_nettype wire

@@ rtl/astm_sqrt_cell.sv @@
// One bit step of the restoring square root chain.
// Depends on astm_pkg.
`default_nettype none
module astm_sqrt_cell
  import astm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic [4:0]        step,
  input  wire side_t             side_in,
  input  wire logic [RAD_W-1:0]  v_in,
  input  wire logic [ROOT_W-1:0] res_in,
  output side_t                  side_out,
  output logic [RAD_W-1:0]       v_out,
  output logic [ROOT_W-1:0]      res_out
);

  side_t              side_r;
  logic [RAD_W-1:0]   v_r, v_nxt;
  logic [ROOT_W-1:0]  res_r, res_nxt, bitv;
  logic [ROOT_W:0]    sum;

  always_comb begin
    bitv = ROOT_W'(1) << (6'd62 - {step, 1'b0});
    sum  = {1'b0, res_in} + {1'b0, bitv};
    if ({2'b00, v_in} >= sum) begin
      v_nxt   = v_in - sum[RAD_W-1:0];
      res_nxt = (res_in >> 1) + bitv;
    end else begin
      v_nxt   = v_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_in;
      v_r    <= v_nxt;
      res_r  <= res_nxt;
    end
  end

  assign side_out = side_r;
  assign v_out    = v_r;
  assign res_out  = res_r;

endmodule
`default_nettype wire

@@ rtl/astm_cordic_cell.sv @@
// One rotation step of the cosine and sine chain.
// Depends on astm_pkg.
`default_nettype none
module astm_cordic_cell
  import astm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic [4:0]           step,
  input  wire side_t                side_in,
  input  wire logic signed [CW-1:0] x_in,
  input  wire logic signed [CW-1:0] y_in,
  input  wire logic signed [CW-1:0] z_in,
  output side_t                     side_out,
  output logic signed [CW-1:0]      x_out,
  output logic signed [CW-1:0]      y_out,
  output logic signed [CW-1:0]      z_out
);

  side_t                side_r;
  logic signed [CW-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, dx, dy, at;

  always_comb begin
    dx = y_in >>> step;
    dy = x_in >>> step;
    at = $signed({2'b00, atan_turn(step)});
    if (!z_in[CW-1]) begin
      x_nxt = x_in - dx;
      y_nxt = y_in + dy;
      z_nxt = z_in - at;
    end else begin
      x_nxt = x_in + dx;
      y_nxt = y_in - dy;
      z_nxt = z_in + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_in;
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      z_r    <= z_nxt;
    end
  end

  assign side_out = side_r;
  assign x_out    = x_r;
  assign y_out    = y_r;
  assign z_out    = z_r;

endmodule
`default_nettype wire

@@ rtl/astm_checker.sv @@
// Port-level checks of the angular spectrum multiplier, bound to its top level.
// Depends on astm_pkg and angular_spectrum_transfer_multiply_top.
`default_nettype none
module astm_checker
  import astm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_re,
  input wire logic [15:0] out_im,
  input wire logic [1:0]  out_region
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im))
    else $error("result changed while stalled");

  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_region == REGION_OUTSIDE || out_region == REGION_EVANESCENT ||
                   out_region == REGION_PROPAGATING))
    else $error("invalid region code");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_region == REGION_OUTSIDE |-> out_re == 16'd0 && out_im == 16'd0)
    else $error("out-of-band result not zero");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind angular_spectrum_transfer_multiply_top astm_checker u_astm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_re     (out_ch.result_re),
  .out_im     (out_ch.result_im),
  .out_region (out_ch.region)
);
`default_nettype wire
